// ----- rtl/prp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and constants of the packet rate pacer.
// ----------------------------------------------------------------------------
package prp_pkg;

   localparam int unsigned RATE_W  = 40;
   localparam int unsigned LIMIT_W = 10;
   localparam int unsigned BYTES_W = 32;
   localparam int unsigned CNT_W   = 64;
   // bytes * 8e6 fits in 56 bits
   localparam int unsigned NUM_W   = 56;
   localparam logic [CNT_W-1:0] GROUP_MIN_DELAY = 64'd10000;
   localparam logic [19:0] US_SCALE = 20'd1000000;
   localparam logic [RATE_W-1:0] RATE_RESET  = 40'd1000000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd64;

   localparam logic [1:0] KIND_DEQ  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RATE_FULL = 3'd1;
   localparam logic [2:0] ST_COMP_FULL = 3'd2;
   localparam logic [2:0] ST_COMP_EMPTY = 3'd3;
   localparam logic [2:0] ST_MISMATCH  = 3'd4;

   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTES_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] packets_done;
      logic [CNT_W-1:0] bytes_done;
      logic [10:0]      packets_pending;
      logic [CNT_W-1:0] bytes_pending;
      logic             can_send;
      logic             sent_event;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_GRP_CHECK, S_GRP_READ, S_GRP_MUL, S_GRP_DIV,
      S_GRP_ADD, S_GRP_END, S_REPORT, S_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request
      logic decode;     // apply enqueue / completion / tick
      logic grp_mul;    // form dividend
      logic div_start;
      logic grp_add;    // accumulate one packet
      logic grp_end;    // arm countdown
      logic report;     // form result word
      logic result;     // strobe result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic try_group;  // decode asked for group formation
      logic can_pull;   // rate queue not empty, delay sum below GROUP_MIN_DELAY
      logic div_done;
   } sts_type;

endpackage

// ----- rtl/packet_rate_pacer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rate_pacer_top
// Packet rate limiter and pacer with rate and completion queues.
// ----------------------------------------------------------------------------
// Usage: drive req_data and pulse start while busy is low; the word is taken
// at that edge. Kinds: packet dequeued, transmit complete, one-us tick.
// Every accepted word yields one result word on rsp_data, marked by
// rsp_valid for one cycle; the receiver cannot stall it.
// Sequence: an item that forms no group passes the decode, group-check,
// report and result states, with rsp_valid high in the result state;
// busy drops right after it. An item that checks for a group also passes
// the group-end state, and each packet pulled adds a queue read, a multiply
// and a radix-2 divide by the link rate before the next group check.
// One item is in work at a time.
// Configuration: csr_valid/csr_ready carry index 0 (rate in bit/s) or 1
// (in-flight limit); write only while busy is low. csr_ready is always high.
// Reset: synchronous; queues empty, counters zero, rate 1e6, limit 64.
// Queue storage is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module packet_rate_pacer_top #(
   parameter int unsigned QUEUE_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  prp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output prp_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [prp_pkg::RATE_W-1:0] csr_data
);
   import prp_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [RATE_W-1:0]   rate_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RATE:  rate_ff  <= csr_data;
            CSR_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   prp_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   prp_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rate     (rate_ff),
      .limit    (limit_ff),
      .rsp_data (rsp_data)
   );

   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy after result strobe");
   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid)
      else $error("result strobe while idle");

endmodule

// ----- rtl/prp_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prp_pkg::NUM_W-1:0]     dividend,
   input  logic [prp_pkg::RATE_W-1:0]    divisor,
   output logic                          done,
   output logic [prp_pkg::NUM_W-1:0]     quotient
);
   import prp_pkg::*;

   localparam int unsigned CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [RATE_W:0]   rem_ff, rem_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[RATE_W-1:0], quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? RATE_W'(1) : divisor;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[RATE_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/prp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_datapath
// Queues, counters, group accumulation and result formation.
// ----------------------------------------------------------------------------
module prp_datapath #(
   parameter int unsigned QUEUE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  prp_pkg::cmd_type            cmd,
   output prp_pkg::sts_type            sts,
   input  prp_pkg::req_type            req_data,
   input  logic [prp_pkg::RATE_W-1:0]  rate,
   input  logic [prp_pkg::LIMIT_W-1:0] limit,
   output prp_pkg::rsp_type            rsp_data
);
   import prp_pkg::*;

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned FW = AW + 1;
   localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

   logic [BYTES_W-1:0] rate_mem [QUEUE_DEPTH];
   logic [BYTES_W-1:0] comp_mem [QUEUE_DEPTH];

   req_type            req_ff;
   logic [AW-1:0]      rrd_ff, rrd_in, rwr_ff, rwr_in, crd_ff, crd_in, cwr_ff, cwr_in;
   logic [FW-1:0]      rfill_ff, rfill_in, cfill_ff, cfill_in;
   logic [CNT_W-1:0]   pk_tx_ff, pk_tx_in, by_tx_ff, by_tx_in;
   logic [CNT_W-1:0]   pk_rt_ff, pk_rt_in, by_rt_ff, by_rt_in;
   logic [CNT_W-1:0]   pk_dq_ff, pk_dq_in, by_dq_ff, by_dq_in;
   logic [FW-1:0]      gpk_ff, gpk_in;
   logic [CNT_W-1:0]   gby_ff, gby_in, delay_ff, delay_in, total_ff, total_in;
   logic               timer_ff, timer_in;
   logic               try_ff, try_in;
   logic [2:0]         status_ff, status_in;
   logic               event_ff, event_in;
   logic [BYTES_W-1:0] rhead_ff, chead_ff;
   logic [NUM_W-1:0]   num_ff;
   logic               div_done;
   logic [NUM_W-1:0]   quot;
   rsp_type            rsp_ff, rsp_in;
   logic [CNT_W-1:0]   pk_done, by_done, pk_pend, dly_dec;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   prp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (rate),
      .done     (div_done),
      .quotient (quot)
   );

   // memories: write on enqueue, registered head reads
   always_ff @(posedge clock) begin
      if (cmd.decode && req_ff.kind == KIND_DEQ && rfill_ff != FULL
          && cfill_ff != FULL) begin
         rate_mem[rwr_ff] <= req_ff.byte_count;
         comp_mem[cwr_ff] <= req_ff.byte_count;
      end
      rhead_ff <= rate_mem[rrd_ff];
      chead_ff <= comp_mem[crd_ff];
   end

   always_comb begin
      rrd_in = rrd_ff; rwr_in = rwr_ff; crd_in = crd_ff; cwr_in = cwr_ff;
      rfill_in = rfill_ff; cfill_in = cfill_ff;
      pk_tx_in = pk_tx_ff; by_tx_in = by_tx_ff; pk_rt_in = pk_rt_ff;
      by_rt_in = by_rt_ff; pk_dq_in = pk_dq_ff; by_dq_in = by_dq_ff;
      gpk_in = gpk_ff; gby_in = gby_ff; delay_in = delay_ff; total_in = total_ff;
      timer_in = timer_ff; try_in = try_ff;
      status_in = status_ff; event_in = event_ff;
      dly_dec = (delay_ff != '0) ? delay_ff - CNT_W'(1) : delay_ff;
      if (cmd.capture) begin
         status_in = ST_OK;
         event_in  = 1'b0;
         try_in    = 1'b0;
      end
      if (cmd.decode) begin
         unique case (req_ff.kind)
            KIND_DEQ: begin
               if (rfill_ff == FULL) begin
                  status_in = ST_RATE_FULL;
               end else if (cfill_ff == FULL) begin
                  status_in = ST_COMP_FULL;
               end else begin
                  pk_dq_in = pk_dq_ff + CNT_W'(1);
                  by_dq_in = by_dq_ff + CNT_W'(req_ff.byte_count);
                  rwr_in   = ptr_next(rwr_ff);
                  cwr_in   = ptr_next(cwr_ff);
                  rfill_in = rfill_ff + FW'(1);
                  cfill_in = cfill_ff + FW'(1);
                  try_in   = !timer_ff && gpk_ff == '0;
               end
            end
            KIND_DONE: begin
               if (cfill_ff == '0) begin
                  status_in = ST_COMP_EMPTY;
               end else if (chead_ff != req_ff.byte_count) begin
                  status_in = ST_MISMATCH;
               end else begin
                  pk_tx_in = pk_tx_ff + CNT_W'(1);
                  by_tx_in = by_tx_ff + CNT_W'(chead_ff);
                  crd_in   = ptr_next(crd_ff);
                  cfill_in = cfill_ff - FW'(1);
                  event_in = (pk_tx_ff + CNT_W'(1)) <= pk_rt_ff;
               end
            end
            KIND_TICK: begin
               if (timer_ff) begin
                  delay_in = dly_dec;
                  if (dly_dec == '0) begin
                     timer_in = 1'b0;
                     if (gpk_ff != '0) begin
                        pk_rt_in = pk_rt_ff + CNT_W'(gpk_ff);
                        by_rt_in = by_rt_ff + gby_ff;
                        gpk_in   = '0;
                        gby_in   = '0;
                        event_in = (pk_rt_ff + CNT_W'(gpk_ff)) <= pk_tx_ff;
                        try_in   = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         total_in = '0;
      end
      if (cmd.grp_add) begin
         total_in = total_ff + CNT_W'(quot);
         gpk_in   = gpk_ff + FW'(1);
         gby_in   = gby_ff + CNT_W'(rhead_ff);
         rrd_in   = ptr_next(rrd_ff);
         rfill_in = rfill_ff - FW'(1);
      end
      if (cmd.grp_end && gpk_ff != '0) begin
         delay_in = total_ff;
         timer_in = 1'b1;
      end
   end

   assign pk_done = (pk_tx_ff < pk_rt_ff) ? pk_tx_ff : pk_rt_ff;
   assign by_done = (by_tx_ff < by_rt_ff) ? by_tx_ff : by_rt_ff;
   assign pk_pend = pk_dq_ff - pk_done;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.report) begin
         rsp_in.status          = status_ff;
         rsp_in.packets_done    = pk_done;
         rsp_in.bytes_done      = by_done;
         rsp_in.packets_pending = pk_pend[10:0];
         rsp_in.bytes_pending   = by_dq_ff - by_done;
         rsp_in.can_send        = pk_pend <= CNT_W'(limit);
         rsp_in.sent_event      = event_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.grp_mul) begin
         num_ff <= NUM_W'(rhead_ff) * NUM_W'(US_SCALE) * NUM_W'(8);
      end
      rsp_ff <= rsp_in;
      if (reset) begin
         rrd_ff <= '0; rwr_ff <= '0; crd_ff <= '0; cwr_ff <= '0;
         rfill_ff <= '0; cfill_ff <= '0;
         pk_tx_ff <= '0; by_tx_ff <= '0; pk_rt_ff <= '0; by_rt_ff <= '0;
         pk_dq_ff <= '0; by_dq_ff <= '0;
         gpk_ff <= '0; gby_ff <= '0; delay_ff <= '0; total_ff <= '0;
         timer_ff <= 1'b0; try_ff <= 1'b0;
         status_ff <= ST_OK; event_ff <= 1'b0;
      end else begin
         rrd_ff <= rrd_in; rwr_ff <= rwr_in; crd_ff <= crd_in; cwr_ff <= cwr_in;
         rfill_ff <= rfill_in; cfill_ff <= cfill_in;
         pk_tx_ff <= pk_tx_in; by_tx_ff <= by_tx_in;
         pk_rt_ff <= pk_rt_in; by_rt_ff <= by_rt_in;
         pk_dq_ff <= pk_dq_in; by_dq_ff <= by_dq_in;
         gpk_ff <= gpk_in; gby_ff <= gby_in; delay_ff <= delay_in;
         total_ff <= total_in;
         timer_ff <= timer_in; try_ff <= try_in;
         status_ff <= status_in; event_ff <= event_in;
      end
   end

   assign sts.try_group = try_ff;
   assign sts.can_pull  = rfill_ff != '0 && total_ff < GROUP_MIN_DELAY;
   assign sts.div_done  = div_done;
   assign rsp_data      = rsp_ff;

endmodule

// ----- rtl/prp_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_control
// Sequencer: decode, group formation walk, result strobe.
// ----------------------------------------------------------------------------
module prp_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  prp_pkg::sts_type  sts,
   output prp_pkg::cmd_type  cmd
);
   import prp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_GRP_CHECK;
         end
         S_GRP_CHECK: begin
            // try_group is set only once decode allowed a new group
            if (sts.try_group && sts.can_pull) begin
               state_in = S_GRP_READ;
            end else if (sts.try_group) begin
               state_in = S_GRP_END;
            end else begin
               state_in = S_REPORT;
            end
         end
         S_GRP_READ: begin
            state_in = S_GRP_MUL;   // head data lands next cycle
         end
         S_GRP_MUL: begin
            cmd.grp_mul = 1'b1;
            state_in    = S_GRP_DIV;
         end
         S_GRP_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_GRP_ADD;
         end
         S_GRP_ADD: begin
            if (sts.div_done) begin
               cmd.grp_add = 1'b1;
               state_in    = S_GRP_CHECK;
            end
         end
         S_GRP_END: begin
            cmd.grp_end = 1'b1;
            state_in    = S_REPORT;
         end
         S_REPORT: begin
            cmd.report = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            cmd.result = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = cmd.result;

endmodule
